// File: rtl/core/signal_phase_learn_countdown_defines.svh
`ifndef SIGNAL_PHASE_LEARN_COUNTDOWN_DEFINES_SVH
`define SIGNAL_PHASE_LEARN_COUNTDOWN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SPL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spl check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SPL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spl check failed");

`endif

// File: rtl/core/spl_pkg.sv
`default_nettype none

package spl_pkg;

    localparam logic [7:0] TICK_INC_RESET = 8'd20;
    localparam logic [7:0] UNIT_THR_RESET = 8'd100;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_THR = 2'd1;

    localparam logic [1:0] C_RED = 2'd0;
    localparam logic [1:0] C_YDN = 2'd1;
    localparam logic [1:0] C_GRN = 2'd2;
    localparam logic [1:0] C_YUP = 2'd3;

    localparam int LB_A0  = 0;
    localparam int LB_YEL = 1;
    localparam int LB_GRN = 2;
    localparam int LB_LRN = 3;
    localparam int LB_CNT = 4;

    typedef enum logic [3:0] {
        PH_LRN_WAIT_RED    = 4'd0,
        PH_LRN_RED         = 4'd1,
        PH_LRN_WAIT_GREEN  = 4'd2,
        PH_LRN_GREEN       = 4'd3,
        PH_LRN_WAIT_YELLOW = 4'd4,
        PH_LRN_YELLOW      = 4'd5,
        PH_DSP_WAIT_RED    = 4'd6,
        PH_DSP_RED         = 4'd7,
        PH_DSP_WAIT_GREEN  = 4'd8,
        PH_DSP_GREEN       = 4'd9,
        PH_DSP_WAIT_YELLOW = 4'd10,
        PH_DSP_YELLOW      = 4'd11
    } phase_t;

    typedef struct packed {
        phase_t          phase;
        logic [7:0]      unit_pre;
        logic [7:0]      blink_pre;
        logic [3:0][7:0] learned;
        logic [3:0][7:0] left;
        logic [3:0]      cnt;
        logic [3:0]      dec;
        logic [4:0]      lamp;
    } spl_state_t;

    typedef struct packed {
        logic red_in;
        logic yellow_in;
        logic green_in;
        logic tick;
    } spl_sample_t;

    typedef struct packed {
        logic       learning_mode;
        logic       lamp_red_or_blink;
        logic       lamp_yellow;
        logic       lamp_green;
        logic       learn_toggle;
        logic       countdown_toggle;
        logic [7:0] red_left;
        logic [7:0] yellow_down_left;
        logic [7:0] green_left;
        logic [7:0] yellow_up_left;
    } spl_result_t;

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    function automatic logic is_display(input phase_t ph);
        return (ph >= PH_DSP_WAIT_RED) && (ph <= PH_DSP_YELLOW);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/spl_if.sv
`default_nettype none

interface spl_in_if;
    logic valid;
    logic ready;
    logic red_in;
    logic yellow_in;
    logic green_in;
    logic tick;

    modport source (output valid, output red_in, output yellow_in, output green_in,
                    output tick, input ready);
    modport sink (input valid, input red_in, input yellow_in, input green_in,
                  input tick, output ready);
endinterface

interface spl_out_if;
    logic       valid;
    logic       ready;
    logic       learning_mode;
    logic       lamp_red_or_blink;
    logic       lamp_yellow;
    logic       lamp_green;
    logic       learn_toggle;
    logic       countdown_toggle;
    logic [7:0] red_left;
    logic [7:0] yellow_down_left;
    logic [7:0] green_left;
    logic [7:0] yellow_up_left;

    modport source (output valid, output learning_mode, output lamp_red_or_blink,
                    output lamp_yellow, output lamp_green, output learn_toggle,
                    output countdown_toggle, output red_left, output yellow_down_left,
                    output green_left, output yellow_up_left, input ready);
    modport sink (input valid, input learning_mode, input lamp_red_or_blink,
                  input lamp_yellow, input lamp_green, input learn_toggle,
                  input countdown_toggle, input red_left, input yellow_down_left,
                  input green_left, input yellow_up_left, output ready);
endinterface

interface spl_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spl_tick.sv
`default_nettype none

module spl_tick
    import spl_pkg::*;
(
    input  spl_state_t cur,
    input  logic       tick,
    input  logic [7:0] tick_inc,
    input  logic [7:0] unit_thr,
    output spl_state_t nxt
);

    logic [7:0] unit_sum;
    logic [7:0] blink_sum;
    logic       unit_step;

    assign unit_sum  = sat_add8(cur.unit_pre, tick_inc);
    assign blink_sum = sat_add8(cur.blink_pre, tick_inc);
    assign unit_step = (|(cur.cnt | cur.dec)) && (unit_sum >= unit_thr);

    always_comb
    begin
        nxt = cur;
        if (tick)
        begin
            nxt.unit_pre = unit_step ? 8'd0 : unit_sum;
            if (unit_step)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (cur.cnt[i])
                    begin
                        nxt.learned[i] = sat_add8(cur.learned[i], 8'd1);
                    end
                    if (cur.dec[i])
                    begin
                        if (cur.left[i] != 8'd0)
                        begin
                            nxt.left[i] = cur.left[i] - 8'd1;
                        end
                        if (nxt.left[i] == 8'd0)
                        begin
                            nxt.dec[i] = 1'b0;
                        end
                    end
                end
                nxt.lamp[LB_LRN] = cur.lamp[LB_LRN] ^ cur.cnt[C_RED];
                nxt.lamp[LB_CNT] = cur.lamp[LB_CNT] ^ cur.dec[C_RED];
            end
            if (!is_display(cur.phase))
            begin
                if (blink_sum >= unit_thr)
                begin
                    nxt.blink_pre   = 8'd0;
                    nxt.lamp[LB_A0] = ~cur.lamp[LB_A0];
                end
                else
                begin
                    nxt.blink_pre = blink_sum;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/spl_seq.sv
`default_nettype none
`include "signal_phase_learn_countdown_defines.svh"

module spl_seq
    import spl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  spl_sample_t smp,
    input  logic [7:0]  tick_inc,
    input  logic [7:0]  unit_thr,
    output spl_result_t res
);

    spl_state_t state_reg;
    spl_state_t state_next;
    spl_state_t ticked;

    spl_tick u_tick (
        .cur      (state_reg),
        .tick     (smp.tick),
        .tick_inc (tick_inc),
        .unit_thr (unit_thr),
        .nxt      (ticked)
    );

    always_comb
    begin
        state_next = ticked;
        unique case (ticked.phase)
            PH_LRN_RED:
            begin
                if (smp.red_in)
                begin
                    if (smp.yellow_in)
                    begin
                        state_next.cnt[C_YDN] = 1'b1;
                    end
                end
                else
                begin
                    state_next.cnt[C_RED]  = 1'b0;
                    state_next.cnt[C_YDN]  = 1'b0;
                    state_next.left[C_RED] = ticked.learned[C_RED];
                    state_next.left[C_YDN] = ticked.learned[C_YDN];
                    state_next.phase       = PH_LRN_WAIT_GREEN;
                end
            end
            PH_LRN_WAIT_GREEN:
            begin
                if (smp.green_in)
                begin
                    state_next.cnt[C_GRN] = 1'b1;
                    state_next.phase      = PH_LRN_GREEN;
                end
            end
            PH_LRN_GREEN:
            begin
                if (!smp.green_in)
                begin
                    state_next.cnt[C_GRN]  = 1'b0;
                    state_next.left[C_GRN] = ticked.learned[C_GRN];
                    if (smp.yellow_in)
                    begin
                        state_next.cnt[C_YUP] = 1'b1;
                        state_next.phase      = PH_LRN_YELLOW;
                    end
                    else
                    begin
                        state_next.phase = PH_LRN_WAIT_YELLOW;
                    end
                end
            end
            PH_LRN_WAIT_YELLOW:
            begin
                if (smp.yellow_in)
                begin
                    state_next.cnt[C_YUP] = 1'b1;
                    state_next.phase      = PH_LRN_YELLOW;
                end
            end
            PH_LRN_YELLOW:
            begin
                if (!smp.yellow_in)
                begin
                    state_next.cnt[C_YUP]  = 1'b0;
                    state_next.left[C_YUP] = ticked.learned[C_YUP];
                    state_next.phase       = PH_DSP_WAIT_RED;
                end
            end
            PH_DSP_WAIT_RED:
            begin
                if (smp.red_in)
                begin
                    state_next.dec[C_RED] = 1'b1;
                    state_next.phase      = PH_DSP_RED;
                end
            end
            PH_DSP_RED:
            begin
                if (smp.red_in)
                begin
                    state_next.lamp[LB_A0] = 1'b1;
                    if (smp.yellow_in)
                    begin
                        state_next.dec[C_YDN]   = 1'b1;
                        state_next.lamp[LB_YEL] = 1'b1;
                    end
                end
                else
                begin
                    state_next.lamp[LB_A0]  = 1'b0;
                    state_next.lamp[LB_YEL] = 1'b0;
                    state_next.dec[C_RED]   = 1'b0;
                    state_next.dec[C_YDN]   = 1'b0;
                    state_next.phase        = PH_DSP_WAIT_GREEN;
                end
            end
            PH_DSP_WAIT_GREEN:
            begin
                if (smp.green_in)
                begin
                    state_next.dec[C_GRN]   = 1'b1;
                    state_next.lamp[LB_GRN] = 1'b1;
                    state_next.phase        = PH_DSP_GREEN;
                end
            end
            PH_DSP_GREEN:
            begin
                if (!smp.green_in)
                begin
                    state_next.lamp[LB_GRN] = 1'b0;
                    state_next.dec[C_GRN]   = 1'b0;
                    if (smp.yellow_in)
                    begin
                        state_next.dec[C_YUP]   = 1'b1;
                        state_next.lamp[LB_YEL] = 1'b1;
                        state_next.phase        = PH_DSP_YELLOW;
                    end
                    else
                    begin
                        state_next.phase = PH_DSP_WAIT_YELLOW;
                    end
                end
            end
            PH_DSP_WAIT_YELLOW:
            begin
                if (smp.yellow_in)
                begin
                    state_next.dec[C_YUP]   = 1'b1;
                    state_next.lamp[LB_YEL] = 1'b1;
                    state_next.phase        = PH_DSP_YELLOW;
                end
            end
            PH_DSP_YELLOW:
            begin
                if (!smp.yellow_in)
                begin
                    state_next.lamp[LB_YEL] = 1'b0;
                    state_next.dec[C_YUP]   = 1'b0;
                    state_next.left         = ticked.learned;
                    state_next.phase        = PH_DSP_WAIT_RED;
                end
            end
            default:
            begin
                // Waiting for red while learning; unused codes behave the same way.
                if (smp.red_in)
                begin
                    state_next.cnt[C_RED] = 1'b1;
                    state_next.phase      = PH_LRN_RED;
                end
                else
                begin
                    state_next.phase = PH_LRN_WAIT_RED;
                end
            end
        endcase
    end

    // An all-zero state is the learning phase that waits for red.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        res.learning_mode     = !is_display(state_next.phase);
        res.lamp_red_or_blink = state_next.lamp[LB_A0];
        res.lamp_yellow       = state_next.lamp[LB_YEL];
        res.lamp_green        = state_next.lamp[LB_GRN];
        res.learn_toggle      = state_next.lamp[LB_LRN];
        res.countdown_toggle  = state_next.lamp[LB_CNT];
        res.red_left          = state_next.left[C_RED];
        res.yellow_down_left  = state_next.left[C_YDN];
        res.green_left        = state_next.left[C_GRN];
        res.yellow_up_left    = state_next.left[C_YUP];
    end

    // Display mode is never left once entered.
    `SPL_ASSERT_NXT(a_display_sticky, clk, rst_n, is_display(state_reg.phase), is_display(state_reg.phase))
    // No countdown runs while durations are still being learned.
    `SPL_ASSERT_IMP(a_no_dec_learning, clk, rst_n, !is_display(state_reg.phase), state_reg.dec == 4'd0)
    // Learning counters are all stopped in display mode.
    `SPL_ASSERT_IMP(a_no_cnt_display, clk, rst_n, is_display(state_reg.phase), state_reg.cnt == 4'd0)
    // The state only moves on a processed beat.
    `SPL_ASSERT_NXT(a_hold_idle, clk, rst_n, !step_en, $stable(state_reg))

endmodule

`default_nettype wire

// File: rtl/core/signal_phase_learn_countdown.sv
// Traffic-signal phase learner with countdown display. Each input beat carries one sample of
// the red, yellow and green lamp levels and a tick flag; each beat produces exactly one result
// beat with the lamp outputs and the four remaining unit counts after that sample. The block
// accepts one beat per clock while no result is held back by output backpressure; each
// beat sits in the input register, then one pass through the state update loads the
// result register. The single state update per beat sets this rate. Results stall only under
// output backpressure; while a result waits, the input register can still take one beat and
// then holds it. The configuration port writes tick_increment at index 0 and unit_threshold
// at index 1; other indexes are ignored, and writes should be made only while no beat is in
// flight.
`default_nettype none

module signal_phase_learn_countdown
    import spl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spl_in_if.sink    sample,
    spl_out_if.source result,
    spl_cfg_if.sink   cfg
);

    logic [7:0]  tick_inc_reg;
    logic [7:0]  unit_thr_reg;
    logic        in_valid_reg;
    spl_sample_t in_data_reg;
    logic        out_valid_reg;
    spl_result_t out_data_reg;
    spl_result_t step_res;
    logic        advance;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_inc_reg <= TICK_INC_RESET;
            unit_thr_reg <= UNIT_THR_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_TICK_INC: tick_inc_reg <= cfg.data;
                CFG_UNIT_THR: unit_thr_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_data_reg <= '{red_in: sample.red_in, yellow_in: sample.yellow_in,
                             green_in: sample.green_in, tick: sample.tick};
        end
    end

    spl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (advance),
        .smp      (in_data_reg),
        .tick_inc (tick_inc_reg),
        .unit_thr (unit_thr_reg),
        .res      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= step_res;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.learning_mode     = out_data_reg.learning_mode;
    assign result.lamp_red_or_blink = out_data_reg.lamp_red_or_blink;
    assign result.lamp_yellow       = out_data_reg.lamp_yellow;
    assign result.lamp_green        = out_data_reg.lamp_green;
    assign result.learn_toggle      = out_data_reg.learn_toggle;
    assign result.countdown_toggle  = out_data_reg.countdown_toggle;
    assign result.red_left          = out_data_reg.red_left;
    assign result.yellow_down_left  = out_data_reg.yellow_down_left;
    assign result.green_left        = out_data_reg.green_left;
    assign result.yellow_up_left    = out_data_reg.yellow_up_left;

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import spl_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
    localparam int SAMPLE_TARGET = 1100;

    class lamp_result_board;
        logic [7:0]  tick_inc;
        logic [7:0]  unit_thr;
        phase_t      ph;
        logic [7:0]  unit_pre;
        logic [7:0]  blink_pre;
        logic [7:0]  learned [4];
        logic [7:0]  left [4];
        logic [3:0]  counting;
        logic [3:0]  falling;
        logic [4:0]  lamps;
        spl_result_t expected_lamps [$];
        int          errors;

        function new();
            tick_inc = TICK_INC_RESET;
            unit_thr = UNIT_THR_RESET;
            ph = PH_LRN_WAIT_RED;
            unit_pre = '0;
            blink_pre = '0;
            foreach (learned[i])
            begin
                learned[i] = '0;
                left[i] = '0;
            end
            counting = '0;
            falling = '0;
            lamps = '0;
            errors = 0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
            if (idx == CFG_TICK_INC)
                tick_inc = val;
            else if (idx == CFG_UNIT_THR)
                unit_thr = val;
        endfunction

        function logic [7:0] clip_add(input logic [7:0] a, input logic [7:0] b);
            int s;
            s = int'(a) + int'(b);
            return (s > 255) ? 8'd255 : s[7:0];
        endfunction

        // The tick works on the counting flags as they stood before the sample.
        function void step_units();
            int i;
            unit_pre = clip_add(unit_pre, tick_inc);
            if ((counting | falling) != 4'd0 && unit_pre >= unit_thr)
            begin
                unit_pre = '0;
                for (i = 0; i < 4; i++)
                begin
                    if (counting[i])
                    begin
                        learned[i] = clip_add(learned[i], 8'd1);
                        if (i == C_RED)
                            lamps[LB_LRN] = ~lamps[LB_LRN];
                    end
                    if (falling[i])
                    begin
                        if (left[i] != 8'd0)
                            left[i] = left[i] - 8'd1;
                        if (i == C_RED)
                            lamps[LB_CNT] = ~lamps[LB_CNT];
                        if (left[i] == 8'd0)
                            falling[i] = 1'b0;
                    end
                end
            end
            if (ph < PH_DSP_WAIT_RED)
            begin
                blink_pre = clip_add(blink_pre, tick_inc);
                if (blink_pre >= unit_thr)
                begin
                    lamps[LB_A0] = ~lamps[LB_A0];
                    blink_pre = '0;
                end
            end
        endfunction

        function void take_sample(input spl_sample_t s);
            spl_result_t r;
            if (s.tick)
                step_units();
            case (ph)
                PH_LRN_WAIT_RED:
                    if (s.red_in)
                    begin
                        counting[C_RED] = 1'b1;
                        ph = PH_LRN_RED;
                    end
                PH_LRN_RED:
                    if (s.red_in)
                    begin
                        if (s.yellow_in)
                            counting[C_YDN] = 1'b1;
                    end
                    else
                    begin
                        counting[C_RED] = 1'b0;
                        counting[C_YDN] = 1'b0;
                        left[C_RED] = learned[C_RED];
                        left[C_YDN] = learned[C_YDN];
                        ph = PH_LRN_WAIT_GREEN;
                    end
                PH_LRN_WAIT_GREEN:
                    if (s.green_in)
                    begin
                        counting[C_GRN] = 1'b1;
                        ph = PH_LRN_GREEN;
                    end
                PH_LRN_GREEN:
                    if (!s.green_in)
                    begin
                        counting[C_GRN] = 1'b0;
                        left[C_GRN] = learned[C_GRN];
                        if (s.yellow_in)
                        begin
                            counting[C_YUP] = 1'b1;
                            ph = PH_LRN_YELLOW;
                        end
                        else
                            ph = PH_LRN_WAIT_YELLOW;
                    end
                PH_LRN_WAIT_YELLOW:
                    if (s.yellow_in)
                    begin
                        counting[C_YUP] = 1'b1;
                        ph = PH_LRN_YELLOW;
                    end
                PH_LRN_YELLOW:
                    if (!s.yellow_in)
                    begin
                        counting[C_YUP] = 1'b0;
                        left[C_YUP] = learned[C_YUP];
                        ph = PH_DSP_WAIT_RED;
                    end
                PH_DSP_WAIT_RED:
                    if (s.red_in)
                    begin
                        falling[C_RED] = 1'b1;
                        ph = PH_DSP_RED;
                    end
                PH_DSP_RED:
                    if (s.red_in)
                    begin
                        lamps[LB_A0] = 1'b1;
                        if (s.yellow_in)
                        begin
                            falling[C_YDN] = 1'b1;
                            lamps[LB_YEL] = 1'b1;
                        end
                    end
                    else
                    begin
                        lamps[LB_A0] = 1'b0;
                        lamps[LB_YEL] = 1'b0;
                        falling[C_RED] = 1'b0;
                        falling[C_YDN] = 1'b0;
                        ph = PH_DSP_WAIT_GREEN;
                    end
                PH_DSP_WAIT_GREEN:
                    if (s.green_in)
                    begin
                        falling[C_GRN] = 1'b1;
                        lamps[LB_GRN] = 1'b1;
                        ph = PH_DSP_GREEN;
                    end
                PH_DSP_GREEN:
                    if (!s.green_in)
                    begin
                        lamps[LB_GRN] = 1'b0;
                        falling[C_GRN] = 1'b0;
                        if (s.yellow_in)
                        begin
                            falling[C_YUP] = 1'b1;
                            lamps[LB_YEL] = 1'b1;
                            ph = PH_DSP_YELLOW;
                        end
                        else
                            ph = PH_DSP_WAIT_YELLOW;
                    end
                PH_DSP_WAIT_YELLOW:
                    if (s.yellow_in)
                    begin
                        falling[C_YUP] = 1'b1;
                        lamps[LB_YEL] = 1'b1;
                        ph = PH_DSP_YELLOW;
                    end
                default:
                    if (!s.yellow_in)
                    begin
                        lamps[LB_YEL] = 1'b0;
                        falling[C_YUP] = 1'b0;
                        foreach (left[i])
                            left[i] = learned[i];
                        ph = PH_DSP_WAIT_RED;
                    end
            endcase
            r.learning_mode = (ph < PH_DSP_WAIT_RED);
            r.lamp_red_or_blink = lamps[LB_A0];
            r.lamp_yellow = lamps[LB_YEL];
            r.lamp_green = lamps[LB_GRN];
            r.learn_toggle = lamps[LB_LRN];
            r.countdown_toggle = lamps[LB_CNT];
            r.red_left = left[C_RED];
            r.yellow_down_left = left[C_YDN];
            r.green_left = left[C_GRN];
            r.yellow_up_left = left[C_YUP];
            expected_lamps.push_back(r);
        endfunction

        function void check_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(input spl_result_t got);
            spl_result_t want;
            if (expected_lamps.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no sample waiting, expected none, got %h",
                         $time, got);
                return;
            end
            want = expected_lamps.pop_front();
            check_field("learning_mode", 8'(want.learning_mode), 8'(got.learning_mode));
            check_field("lamp_red_or_blink", 8'(want.lamp_red_or_blink),
                        8'(got.lamp_red_or_blink));
            check_field("lamp_yellow", 8'(want.lamp_yellow), 8'(got.lamp_yellow));
            check_field("lamp_green", 8'(want.lamp_green), 8'(got.lamp_green));
            check_field("learn_toggle", 8'(want.learn_toggle), 8'(got.learn_toggle));
            check_field("countdown_toggle", 8'(want.countdown_toggle),
                        8'(got.countdown_toggle));
            check_field("red_left", want.red_left, got.red_left);
            check_field("yellow_down_left", want.yellow_down_left, got.yellow_down_left);
            check_field("green_left", want.green_left, got.green_left);
            check_field("yellow_up_left", want.yellow_up_left, got.yellow_up_left);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    int samples_sent;
    lamp_result_board board;

    spl_in_if sample_bus ();
    spl_out_if result_bus ();
    spl_cfg_if cfg_bus ();

    signal_phase_learn_countdown dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        result_bus.ready <= calm || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        if (sample_bus.valid && sample_bus.ready)
            board.take_sample({sample_bus.red_in, sample_bus.yellow_in,
                               sample_bus.green_in, sample_bus.tick});
        if (result_bus.valid && result_bus.ready)
            board.check_result({result_bus.learning_mode, result_bus.lamp_red_or_blink,
                                result_bus.lamp_yellow, result_bus.lamp_green,
                                result_bus.learn_toggle, result_bus.countdown_toggle,
                                result_bus.red_left, result_bus.yellow_down_left,
                                result_bus.green_left, result_bus.yellow_up_left});
    end

    function automatic logic coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [7:0] pick_setting();
        case ($urandom_range(3))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_sample(input logic r, input logic y, input logic g, input logic t);
        while (!calm && $urandom_range(99) < 16)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid <= 1'b1;
        sample_bus.red_in <= r;
        sample_bus.yellow_in <= y;
        sample_bus.green_in <= g;
        sample_bus.tick <= t;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        samples_sent++;
    endtask

    task automatic settle();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (board.expected_lamps.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        board.set_reg(idx, val);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // One display cycle of well-formed lamp sequences with random content.
    task automatic run_cycle(input int tp);
        int n;
        n = $urandom_range(3);
        repeat (n) send_sample(1'b0, coin(50), coin(50), coin(tp));
        n = $urandom_range(1, 12);
        repeat (n) send_sample(1'b1, coin(50), coin(20), coin(tp));
        send_sample(1'b0, coin(30), 1'b0, coin(tp));
        n = $urandom_range(3);
        repeat (n) send_sample(1'b0, coin(40), 1'b0, coin(tp));
        n = $urandom_range(1, 12);
        repeat (n) send_sample(coin(20), coin(30), 1'b1, coin(tp));
        if (coin(50))
            send_sample(coin(20), 1'b1, 1'b0, coin(tp));
        else
        begin
            send_sample(coin(20), 1'b0, 1'b0, coin(tp));
            n = $urandom_range(3);
            repeat (n) send_sample(coin(20), 1'b0, coin(20), coin(tp));
        end
        n = $urandom_range(1, 8);
        repeat (n) send_sample(coin(20), 1'b1, coin(20), coin(tp));
        send_sample(coin(20), 1'b0, coin(20), coin(tp));
    endtask

    initial
    begin
        logic quiet_red;
        int cycle_no;
        board = new();
        rst_n = 1'b0;
        calm = 1'b0;
        samples_sent = 0;
        sample_bus.valid = 1'b0;
        sample_bus.red_in = 1'b0;
        sample_bus.yellow_in = 1'b0;
        sample_bus.green_in = 1'b0;
        sample_bus.tick = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_TICK_INC;
        cfg_bus.data = '0;
        result_bus.ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Learning: ticks before red leave the unit prescaler full, so the first red
        // tick completes a unit at once. Some runs send no tick while red is lit, so
        // the red time learned is the one unit completed by the tick that ends red.
        quiet_red = coin(25);
        repeat (6) send_sample(1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0);
        repeat (5) send_sample(1'b1, 1'b0, 1'b0, !quiet_red);
        repeat (10) send_sample(1'b1, 1'b1, 1'b0, !quiet_red);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1, 1'b0);
        settle();
        write_reg(CFG_TICK_INC, 8'd255);
        write_reg(CFG_UNIT_THR, 8'd255);
        repeat (260) send_sample(1'b0, 1'b0, 1'b1, 1'b1);
        settle();
        write_reg(CFG_TICK_INC, 8'd1);
        write_reg(CFG_UNIT_THR, 8'd1);
        repeat (4) send_sample(1'b0, 1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0);

        // First display cycle runs every countdown down to zero and past it.
        send_sample(1'b1, 1'b0, 1'b0, 1'b0);
        repeat (5) send_sample(1'b1, 1'b1, 1'b0, 1'b1);
        repeat (3) send_sample(1'b1, 1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1);
        repeat (258) send_sample(1'b0, 1'b0, 1'b1, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0, 1'b1);
        repeat (6) send_sample(1'b0, 1'b1, 1'b0, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0);

        cycle_no = 0;
        while (samples_sent < SAMPLE_TARGET)
        begin
            calm <= (cycle_no >= 10 && cycle_no < 20);
            if (coin(12))
            begin
                settle();
                write_reg(CFG_TICK_INC, pick_setting());
                write_reg(CFG_UNIT_THR, pick_setting());
                if (coin(20))
                    write_reg(CFG_SPARE, 8'($urandom_range(255)));
            end
            else if (coin(4))
                settle();
            if (coin(10))
                repeat ($urandom_range(1, 10))
                    send_sample(coin(50), coin(50), coin(50), coin(50));
            else
                run_cycle($urandom_range(20, 95));
            cycle_no++;
        end

        settle();
        repeat (10) @(posedge clk);
        if (board.errors == 0 && board.expected_lamps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
